[rtl/core/rov_pkg.sv]
`timescale 1ns / 1ps
// rov_pkg: shared types, constants and mask functions for the route origin validator
// no dependencies
package rov_pkg;

    localparam int ENTRIES   = 1024;
    localparam int IDX_W     = $clog2(ENTRIES);
    localparam int CNT_W     = 11;
    localparam int QDEPTH    = 2;

    localparam logic [1:0] ROV_VALID    = 2'd0;
    localparam logic [1:0] ROV_INVALID  = 2'd1;
    localparam logic [1:0] ROV_NOTFOUND = 2'd2;

    localparam logic [1:0] INS_ADDED    = 2'd0;
    localparam logic [1:0] INS_DUP      = 2'd1;
    localparam logic [1:0] INS_REJECTED = 2'd2;
    localparam logic [1:0] INS_FULL     = 2'd3;

    localparam logic [7:0] V4_MAX = 8'd32;
    localparam logic [7:0] V6_MAX = 8'd128;

    typedef enum logic [0:0] {
        K_INSERT   = 1'b0,
        K_VALIDATE = 1'b1
    } t_kind;

    // classified word handed from front to back
    typedef struct packed {
        t_kind       kind;
        logic        rejected;
        logic        is_ipv6;
        logic [63:0] addr_hi;
        logic [63:0] addr_lo;
        logic [7:0]  prefix_len;
        logic [31:0] asn;
        logic [7:0]  max_len;
    } t_cmd;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FINISH,
        S_OUT
    } t_state;

    function automatic logic [63:0] mask_high(input logic [7:0] len);
        logic [63:0] m;
        if (len == 8'd0) m = '0;
        else if (len >= 8'd64) m = '1;
        else m = ~64'd0 << (7'd64 - {1'b0, len[5:0]});
        return m;
    endfunction

    function automatic logic [63:0] mask_low(input logic [7:0] len);
        logic [63:0] m;
        if (len <= 8'd64) m = '0;
        else if (len >= 8'd128) m = '1;
        else m = ~64'd0 << (8'd128 - len);
        return m;
    endfunction

endpackage

[rtl/core/rov_front.sv]
`timescale 1ns / 1ps
// rov_front: accepts words, checks insert lengths, masks the prefix and queues them
// depends on rov_pkg
module rov_front
    import rov_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_kind,
    input  logic        i_is_ipv6,
    input  logic [63:0] i_addr_hi,
    input  logic [63:0] i_addr_lo,
    input  logic [7:0]  i_prefix_len,
    input  logic [31:0] i_asn,
    input  logic [7:0]  i_max_len,
    output logic        o_q_valid,
    input  logic        i_q_pop,
    output t_cmd        o_q_cmd
);

    t_cmd        r_q [QDEPTH];
    logic [0:0]  r_wp, r_rp;
    logic [1:0]  r_cnt;
    t_cmd        n_cmd;
    logic        push;
    logic [7:0]  limit;

    always_comb begin
        limit          = i_is_ipv6 ? V6_MAX : V4_MAX;
        n_cmd.kind     = t_kind'(i_kind);
        n_cmd.is_ipv6  = i_is_ipv6;
        n_cmd.asn      = i_asn;
        n_cmd.max_len  = i_max_len;
        n_cmd.prefix_len = i_prefix_len;
        n_cmd.rejected = (i_max_len < i_prefix_len) || (i_max_len > limit);
        // inserts are stored masked, validates keep the full address
        if (i_kind == K_INSERT) begin
            n_cmd.addr_hi = i_addr_hi & mask_high(i_prefix_len);
            n_cmd.addr_lo = i_addr_lo & mask_low(i_prefix_len);
        end else begin
            n_cmd.addr_hi = i_addr_hi;
            n_cmd.addr_lo = i_addr_lo;
        end
    end

    assign o_stall   = (r_cnt == 2'(QDEPTH));
    assign push      = i_valid && !o_stall;
    assign o_q_valid = (r_cnt != 2'd0);
    assign o_q_cmd   = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (push) r_q[r_wp] <= n_cmd;
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) r_wp <= r_wp + 1'b1;
            if (i_q_pop) r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + 2'(push) - 2'(i_q_pop);
        end
    end

endmodule

[rtl/core/rov_back.sv]
`timescale 1ns / 1ps
// rov_back: table memory and scan sequencer for inserts and validates
// depends on rov_pkg
module rov_back
    import rov_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_q_valid,
    output logic        o_q_pop,
    input  t_cmd        i_q_cmd,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_rov_state,
    output logic [1:0]  o_insert_status,
    output logic [10:0] o_entry_count
);

    logic [63:0] r_mem_hi [ENTRIES];
    logic [63:0] r_mem_lo [ENTRIES];
    logic [48:0] r_mem_meta [ENTRIES];

    t_state      r_state, n_state;
    t_cmd        r_cmd;
    logic [CNT_W-1:0] r_count, n_count;
    logic [CNT_W-1:0] r_idx, n_idx;     // read address issued
    logic        r_rd_v, n_rd_v;        // registered read data valid
    logic [63:0] r_rd_hi, r_rd_lo;
    logic [48:0] r_rd_meta;
    logic        r_hit, n_hit, r_cov, n_cov;
    logic        r_outv, n_outv;
    logic [1:0]  r_rov, n_rov, r_ins, n_ins;
    logic        wr_en;
    logic [1:0]  r_o_rov, r_o_ins;
    logic [CNT_W-1:0] r_o_cnt;

    logic        e_fam;
    logic [7:0]  e_len, e_ml;
    logic [31:0] e_asn;
    logic        dup_m, cov_m, val_m;

    always_comb begin
        e_fam = r_rd_meta[48];
        e_len = r_rd_meta[47:40];
        e_asn = r_rd_meta[39:8];
        e_ml  = r_rd_meta[7:0];
        dup_m = (r_rd_hi == r_cmd.addr_hi) && (r_rd_lo == r_cmd.addr_lo)
             && (r_rd_meta == {r_cmd.is_ipv6, r_cmd.prefix_len, r_cmd.asn, r_cmd.max_len});
        cov_m = (e_fam == r_cmd.is_ipv6) && (e_len <= r_cmd.prefix_len)
             && ((r_cmd.addr_hi & mask_high(e_len)) == r_rd_hi)
             && ((r_cmd.addr_lo & mask_low(e_len)) == r_rd_lo);
        val_m = cov_m && (e_asn == r_cmd.asn) && (e_asn != 32'd0)
             && (r_cmd.prefix_len <= e_ml);
    end

    always_ff @(posedge i_clk) begin
        r_rd_hi   <= r_mem_hi[r_idx[IDX_W-1:0]];
        r_rd_lo   <= r_mem_lo[r_idx[IDX_W-1:0]];
        r_rd_meta <= r_mem_meta[r_idx[IDX_W-1:0]];
        if (wr_en) begin
            r_mem_hi[r_count[IDX_W-1:0]]   <= r_cmd.addr_hi;
            r_mem_lo[r_count[IDX_W-1:0]]   <= r_cmd.addr_lo;
            r_mem_meta[r_count[IDX_W-1:0]] <= {r_cmd.is_ipv6, r_cmd.prefix_len,
                                                r_cmd.asn, r_cmd.max_len};
        end
    end

    always_comb begin
        n_state = r_state;
        n_count = r_count;
        n_idx   = r_idx;
        n_rd_v  = 1'b0;
        n_hit   = r_hit;
        n_cov   = r_cov;
        n_outv  = r_outv && i_stall;
        n_rov   = r_rov;
        n_ins   = r_ins;
        o_q_pop = 1'b0;
        wr_en   = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop = 1'b1;
                    n_idx   = '0;
                    n_hit   = 1'b0;
                    n_cov   = 1'b0;
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                // one entry per cycle across every stored entry; a rejected insert skips the scan
                if (r_rd_v) begin
                    if (r_cmd.kind == K_INSERT) n_hit = r_hit | dup_m;
                    else begin
                        n_cov = r_cov | cov_m;
                        n_hit = r_hit | val_m;
                    end
                end
                if (r_cmd.kind == K_INSERT && r_cmd.rejected) n_state = S_FINISH;
                else if (r_idx < r_count) begin
                    n_idx  = r_idx + 1'b1;
                    n_rd_v = 1'b1;
                end else if (!r_rd_v) n_state = S_FINISH;
            end
            S_FINISH: begin
                if (r_cmd.kind == K_INSERT) begin
                    n_rov = ROV_NOTFOUND;
                    if (r_cmd.rejected) n_ins = INS_REJECTED;
                    else if (r_hit) n_ins = INS_DUP;
                    else if (r_count >= CNT_W'(ENTRIES)) n_ins = INS_FULL;
                    else begin
                        n_ins   = INS_ADDED;
                        wr_en   = 1'b1;
                        n_count = r_count + 1'b1;
                    end
                end else begin
                    n_ins = INS_ADDED;
                    n_rov = r_hit ? ROV_VALID : (r_cov ? ROV_INVALID : ROV_NOTFOUND);
                end
                n_state = S_OUT;
            end
            S_OUT: begin
                // output register frees once the previous word has gone
                if (!(r_outv && i_stall)) begin
                    n_outv  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_cmd <= o_q_pop ? i_q_cmd : r_cmd;
        r_hit <= n_hit;
        r_cov <= n_cov;
        r_idx <= n_idx;
        r_rov <= n_rov;
        r_ins <= n_ins;
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_rd_v  <= 1'b0;
            r_outv  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_rd_v  <= n_rd_v;
            r_outv  <= n_outv;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (r_state == S_OUT && !(r_outv && i_stall)) begin
            r_o_rov <= r_rov;
            r_o_ins <= r_ins;
            r_o_cnt <= r_count;
        end
    end

    assign o_valid         = r_outv;
    assign o_rov_state     = r_o_rov;
    assign o_insert_status = r_o_ins;
    assign o_entry_count   = r_o_cnt;

endmodule

[rtl/core/route_origin_validator.sv]
`timescale 1ns / 1ps
// route_origin_validator: top level of the route origin validation block
// depends on rov_pkg, rov_front, rov_back
//
// usage
//   input channel: i_valid / o_stall, one word is an insert of a vrp entry
//   (i_kind 0) or a route origin check (i_kind 1); taken on a clock edge
//   with i_valid high and o_stall low
//   output channel: o_valid / i_stall, one result word per input word, in
//   order; the word holds until an edge with i_stall low
//   the front stage checks lengths and masks the prefix, then queues the
//   word in a two-entry fifo, so up to two words are taken while the back
//   stage is busy
//   the back stage scans the stored table one entry per cycle through a
//   registered memory read; a rejected insert skips the scan
//   reset clears the entry count and all handshake state; the table
//   memory is not cleared, only entries below the count are ever compared
//   a stalled receiver holds the result register, the back stage waits
//   with its next result and the fifo then fills and raises o_stall
module route_origin_validator
    import rov_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_kind,
    input  logic        i_is_ipv6,
    input  logic [63:0] i_addr_hi,
    input  logic [63:0] i_addr_lo,
    input  logic [7:0]  i_prefix_len,
    input  logic [31:0] i_asn,
    input  logic [7:0]  i_max_len,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_rov_state,
    output logic [1:0]  o_insert_status,
    output logic [10:0] o_entry_count
);

    logic q_valid, q_pop;
    t_cmd q_cmd;

    // accept, classify and queue
    rov_front u_front (
        .i_clk, .i_rst_n, .i_valid, .o_stall, .i_kind, .i_is_ipv6,
        .i_addr_hi, .i_addr_lo, .i_prefix_len, .i_asn, .i_max_len,
        .o_q_valid(q_valid), .i_q_pop(q_pop), .o_q_cmd(q_cmd)
    );

    // table scan and result register
    rov_back u_back (
        .i_clk, .i_rst_n,
        .i_q_valid(q_valid), .o_q_pop(q_pop), .i_q_cmd(q_cmd),
        .o_valid, .i_stall, .o_rov_state, .o_insert_status, .o_entry_count
    );

endmodule

[bench/tb_top.sv]
`timescale 1ns / 1ps
// tb_top: self-checking bench for route_origin_validator, vrp inserts and origin checks
// depends on rov_pkg and the route_origin_validator rtl
module tb_top;
    import rov_pkg::*;

    // one expected result word
    typedef struct {
        logic [1:0]  rov;
        logic [1:0]  status;
        logic [10:0] count;
    } t_verdict;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic        i_kind = 1'b0;
    logic        i_is_ipv6 = 1'b0;
    logic [63:0] i_addr_hi = '0;
    logic [63:0] i_addr_lo = '0;
    logic [7:0]  i_prefix_len = '0;
    logic [31:0] i_asn = '0;
    logic [7:0]  i_max_len = '0;
    logic        o_valid;
    logic        i_stall = 1'b1;
    logic [1:0]  o_rov_state;
    logic [1:0]  o_insert_status;
    logic [10:0] o_entry_count;

    route_origin_validator dut (.*);

    // 2 ns period
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // predictor copy of the vrp table
    logic [63:0] vrp_hi [ENTRIES];
    logic [63:0] vrp_lo [ENTRIES];
    logic [48:0] vrp_meta [ENTRIES];   // {ipv6, len, asn, max_len}
    int          vrp_count = 0;

    t_verdict    pending_verdicts [$];
    int          errors = 0;
    int          idle_cycles = 0;
    int          words_sent = 0;
    int          words_checked = 0;
    int          hits [4];             // valid, invalid, notfound or insert; [3] unused
    int          ins_hits [4];
    bit          jitter_on = 1'b0;
    int          hold_left = 0;
    bit          hold_req = 1'b0;

    localparam int WATCHDOG_LIMIT = 20000;

    // ones in the top len bits of the upper half
    function automatic logic [63:0] upper_mask(input int len);
        if (len >= 64) return '1;
        return ~({64{1'b1}} >> len);
    endfunction

    function automatic logic [63:0] lower_mask(input int len);
        if (len <= 64) return '0;
        if (len >= 128) return '1;
        return ~({64{1'b1}} >> (len - 64));
    endfunction

    // works out the result of one word and updates the table copy
    function automatic t_verdict classify_word(input t_kind kind, input logic fam,
            input logic [63:0] hi, input logic [63:0] lo, input logic [7:0] len,
            input logic [31:0] asn, input logic [7:0] ml);
        t_verdict    v;
        logic [63:0] ph;
        logic [63:0] pl;
        logic [48:0] meta;
        logic [7:0]  elen;
        bit          covered;
        bit          matched;
        bit          dup;
        v.rov = ROV_NOTFOUND;
        v.status = INS_ADDED;
        if (kind == K_INSERT) begin
            if (ml < len || ml > (fam ? V6_MAX : V4_MAX)) begin
                v.status = INS_REJECTED;
            end else begin
                ph = hi & upper_mask(len);
                pl = lo & lower_mask(len);
                meta = {fam, len, asn, ml};
                dup = 1'b0;
                for (int i = 0; i < vrp_count; i++)
                    if (vrp_hi[i] == ph && vrp_lo[i] == pl && vrp_meta[i] == meta) dup = 1'b1;
                if (dup) begin
                    v.status = INS_DUP;
                end else if (vrp_count >= ENTRIES) begin
                    v.status = INS_FULL;
                end else begin
                    vrp_hi[vrp_count] = ph;
                    vrp_lo[vrp_count] = pl;
                    vrp_meta[vrp_count] = meta;
                    vrp_count++;
                end
            end
        end else begin
            covered = 1'b0;
            matched = 1'b0;
            for (int i = 0; i < vrp_count; i++) begin
                elen = vrp_meta[i][47:40];
                if (vrp_meta[i][48] == fam && elen <= len &&
                    (hi & upper_mask(elen)) == vrp_hi[i] &&
                    (lo & lower_mask(elen)) == vrp_lo[i]) begin
                    covered = 1'b1;
                    // zero origin never matches
                    if (vrp_meta[i][39:8] == asn && asn != 0 && len <= vrp_meta[i][7:0])
                        matched = 1'b1;
                end
            end
            v.rov = matched ? ROV_VALID : (covered ? ROV_INVALID : ROV_NOTFOUND);
        end
        v.count = 11'(vrp_count);
        return v;
    endfunction

    // offers one word, idling first at random when jitter is on, and predicts it once taken
    task automatic send_word(input t_kind kind, input logic fam, input logic [63:0] hi,
            input logic [63:0] lo, input logic [7:0] len, input logic [31:0] asn,
            input logic [7:0] ml);
        t_verdict v;
        @(negedge i_clk);
        while (jitter_on && $urandom_range(99) < 38) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_kind <= kind;
        i_is_ipv6 <= fam;
        i_addr_hi <= hi;
        i_addr_lo <= lo;
        i_prefix_len <= len;
        i_asn <= asn;
        i_max_len <= ml;
        forever begin
            @(posedge i_clk);
            if (!o_stall) break;
        end
        v = classify_word(kind, fam, hi, lo, len, asn, ml);
        pending_verdicts.push_back(v);
        words_sent++;
    endtask

    task automatic lower_valid();
        @(negedge i_clk);
        i_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (pending_verdicts.size() != 0) @(posedge i_clk);
    endtask

    // receiver side: random stall when jitter is on, or a long hold when asked
    always @(negedge i_clk) begin
        if (hold_req && hold_left == 0) begin
            hold_left = 400;
            hold_req = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_stall <= 1'b1;
        end else begin
            i_stall <= jitter_on ? ($urandom_range(99) < 38) : 1'b0;
        end
    end

    // result checker and watchdog
    always @(posedge i_clk) begin
        t_verdict v;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_verdicts.size() == 0) begin
                $display("%0t: result word with nothing expected rov %0d status %0d count %0d",
                         $time, o_rov_state, o_insert_status, o_entry_count);
                errors++;
            end else begin
                v = pending_verdicts.pop_front();
                if (o_rov_state !== v.rov) begin
                    $display("%0t: rov_state expected %0d actual %0d", $time, v.rov, o_rov_state);
                    errors++;
                end
                if (o_insert_status !== v.status) begin
                    $display("%0t: insert_status expected %0d actual %0d",
                             $time, v.status, o_insert_status);
                    errors++;
                end
                if (o_entry_count !== v.count) begin
                    $display("%0t: entry_count expected %0d actual %0d",
                             $time, v.count, o_entry_count);
                    errors++;
                end
                if (v.status == INS_ADDED && v.rov != ROV_NOTFOUND) hits[v.rov]++;
                else if (v.rov == ROV_NOTFOUND) hits[2]++;
                ins_hits[v.status]++;
                words_checked++;
            end
        end
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
                $display("route_origin_validator verification failed");
                $finish;
            end
        end
    end

    // corners: empty table, masking, lengths, duplicates, zero origin
    task automatic test_directed();
        send_word(K_VALIDATE, 1'b0, 64'h0A01_0203_0000_0000, '0, 8'd24, 32'd65000, 8'd0);
        send_word(K_INSERT, 1'b0, 64'h0A12_3456_789A_BCDE, '0, 8'd8, 32'd65000, 8'd24);
        send_word(K_INSERT, 1'b0, 64'h0AFF_FFFF_FFFF_FFFF, '1, 8'd8, 32'd65000, 8'd24);
        send_word(K_INSERT, 1'b0, 64'h0B00_0000_0000_0000, '0, 8'd16, 32'd1, 8'd15);
        send_word(K_INSERT, 1'b0, 64'h0B00_0000_0000_0000, '0, 8'd16, 32'd1, 8'd33);
        send_word(K_INSERT, 1'b1, '1, '1, 8'd128, 32'hFFFF_FFFF, 8'd129);
        send_word(K_INSERT, 1'b1, '1, '1, 8'd128, 32'hFFFF_FFFF, 8'd128);
        send_word(K_INSERT, 1'b0, '1, '0, 8'd0, 32'd0, 8'd0);
        send_word(K_INSERT, 1'b0, 64'hFFFF_FFFF_0000_0000, '0, 8'd32, 32'hFFFF_FFFF, 8'd32);
        send_word(K_INSERT, 1'b1, 64'h2001_0DB8_0000_0000, 64'h8000_0000_0000_0000, 8'd65,
                  32'd64512, 8'd96);
        send_word(K_VALIDATE, 1'b0, 64'h0A01_0200_0000_0000, '0, 8'd24, 32'd65000, 8'd0);
        send_word(K_VALIDATE, 1'b0, 64'h0A01_0200_0000_0000, '0, 8'd25, 32'd65000, 8'd0);
        send_word(K_VALIDATE, 1'b0, 64'h0A01_0200_0000_0000, '0, 8'd24, 32'd65001, 8'd0);
        send_word(K_VALIDATE, 1'b0, 64'h0A01_0200_0000_0000, '0, 8'd16, 32'd0, 8'd0);
        send_word(K_VALIDATE, 1'b0, 64'h0000_0000_0000_0000, '0, 8'd0, 32'd0, 8'd255);
        send_word(K_VALIDATE, 1'b0, 64'hFFFF_FFFF_FFFF_FFFF, '1, 8'd32, 32'hFFFF_FFFF, 8'd0);
        send_word(K_VALIDATE, 1'b0, 64'hFFFF_FFFF_0000_0000, '0, 8'd128, 32'hFFFF_FFFF, 8'd0);
        send_word(K_VALIDATE, 1'b1, '1, '1, 8'd128, 32'hFFFF_FFFF, 8'd0);
        send_word(K_VALIDATE, 1'b1, 64'h2001_0DB8_0000_0000, 64'h8123_0000_0000_0001, 8'd96,
                  32'd64512, 8'd0);
        send_word(K_VALIDATE, 1'b1, 64'h2001_0DB8_0000_0000, 64'h0123_0000_0000_0001, 8'd96,
                  32'd64512, 8'd0);
        send_word(K_VALIDATE, 1'b1, 64'h2001_0DB8_0000_0000, 64'h8000_0000_0000_0000, 8'd64,
                  32'd64512, 8'd0);
        lower_valid();
    endtask

    // mostly well-formed traffic built around the stored entries
    task automatic test_random(input int n);
        int          pick;
        int          elen;
        int          lim;
        logic        fam;
        logic [63:0] hi;
        logic [63:0] lo;
        logic [7:0]  len;
        logic [7:0]  ml;
        logic [31:0] asn;
        for (int k = 0; k < n; k++) begin
            pick = $urandom_range(vrp_count - 1);
            hi = {$urandom, $urandom};
            lo = {$urandom, $urandom};
            asn = ($urandom_range(3) == 0) ? $urandom_range(3) : $urandom;
            if ($urandom_range(99) < 55) begin
                // origin check near an entry
                fam = vrp_meta[pick][48];
                elen = vrp_meta[pick][47:40];
                lim = fam ? 128 : 32;
                hi = vrp_hi[pick] | (hi & ~upper_mask(elen));
                lo = vrp_lo[pick] | (lo & ~lower_mask(elen));
                if (!fam && $urandom_range(3) != 0) lo = '0;
                len = (elen < lim && $urandom_range(9) != 0) ? 8'($urandom_range(lim, elen))
                                                             : 8'($urandom_range(255, elen));
                case ($urandom_range(3))
                    0, 1: asn = vrp_meta[pick][39:8];
                    2: asn = 32'd0;
                    default: ;
                endcase
                if ($urandom_range(19) == 0) len = 8'($urandom_range(elen));
                send_word(K_VALIDATE, fam, hi, lo, len, asn, 8'($urandom_range(128)));
            end else if ($urandom_range(99) < 20) begin
                // exact repeat of a stored entry, host bits differ
                elen = vrp_meta[pick][47:40];
                send_word(K_INSERT, vrp_meta[pick][48], vrp_hi[pick] | (hi & ~upper_mask(elen)),
                          vrp_lo[pick] | (lo & ~lower_mask(elen)), 8'(elen),
                          vrp_meta[pick][39:8], vrp_meta[pick][7:0]);
            end else begin
                fam = $urandom_range(1);
                lim = fam ? 128 : 32;
                if ($urandom_range(1)) begin
                    // more specific entry under an existing one
                    fam = vrp_meta[pick][48];
                    lim = fam ? 128 : 32;
                    elen = vrp_meta[pick][47:40];
                    hi = vrp_hi[pick] | (hi & ~upper_mask(elen));
                    lo = vrp_lo[pick] | (lo & ~lower_mask(elen));
                    len = 8'($urandom_range(lim, (elen < lim) ? elen : lim));
                end else begin
                    len = 8'($urandom_range(lim));
                end
                if (!fam) lo = '0;
                ml = ($urandom_range(9) == 0) ? 8'($urandom_range(128))
                                             : 8'($urandom_range(lim, len));
                if ($urandom_range(2) == 0) asn = vrp_meta[pick][39:8];
                send_word(K_INSERT, fam, hi, lo, len, asn, ml);
            end
        end
        lower_valid();
    endtask

    // receiver holds off while words keep coming, so the input stalls
    task automatic test_backpressure();
        hold_req = 1'b1;
        for (int k = 0; k < 8; k++)
            send_word(K_VALIDATE, 1'b0, {$urandom, 32'd0}, '0, 8'($urandom_range(32)),
                      $urandom, 8'd0);
        lower_valid();
    endtask

    // insert paths on a well-filled table: new, duplicate and rejected entries
    task automatic test_insert_paths();
        int base;
        base = vrp_count;
        send_word(K_INSERT, 1'b1, 64'hFEED_0000_0000_0000 | 64'(base), '0, 8'd64, 32'd7, 8'd64);
        send_word(K_INSERT, 1'b0, 64'h0A12_3456_789A_BCDE, '0, 8'd8, 32'd65000, 8'd24);
        send_word(K_INSERT, 1'b0, 64'h0A00_0000_0000_0000, '0, 8'd8, 32'd65000, 8'd7);
        send_word(K_INSERT, 1'b0, 64'h0C00_0000_0000_0000, '0, 8'd8, 32'd65000, 8'd8);
        jitter_on = 1'b1;
        test_random(20);
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        jitter_on = 1'b1;
        test_random(260);
        test_backpressure();
        wait_drained();
        // long stretch with no idling on either side
        jitter_on = 1'b0;
        test_random(150);
        jitter_on = 1'b1;
        test_random(120);
        jitter_on = 1'b0;
        test_insert_paths();
        wait_drained();
        repeat (1100) @(posedge i_clk);
        $display("%0d words sent, %0d results checked, table ended at %0d entries",
                 words_sent, words_checked, vrp_count);
        $display("checks valid %0d invalid %0d; inserts dup %0d rejected %0d full %0d",
                 hits[0], hits[1], ins_hits[1], ins_hits[2], ins_hits[3]);
        if (errors == 0) begin
            $display("route_origin_validator verification clean");
        end else begin
            $display("route_origin_validator verification failed");
        end
        $finish;
    end

endmodule

[filelist.f]
rtl/core/rov_pkg.sv
rtl/core/rov_front.sv
rtl/core/rov_back.sv
rtl/core/route_origin_validator.sv
bench/tb_top.sv
